FILE: rtl/kaf_pkg.sv
// ----------------------------------------------------------------------------
// kaf_pkg: shared types and constants for the Kalman angle filter
// Holds fixed-point widths, register indexes and the saturation helper.
// ----------------------------------------------------------------------------
package kaf_pkg;

  localparam int unsigned RegW   = 31;
  localparam int unsigned DataW  = 32;
  localparam int unsigned TimeW  = 24;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegAngleNoise = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBiasNoise  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMeasNoise  = 2'd2;

  localparam logic [RegW-1:0] AngleNoiseRst = 31'd16777;
  localparam logic [RegW-1:0] BiasNoiseRst  = 31'd50332;
  localparam logic [RegW-1:0] MeasNoiseRst  = 31'd503316;

  // Command from the sequencer to the divider
  typedef struct packed {
    logic              start;
    logic signed [31:0] num;
    logic signed [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] quot;
  } div_rsp_t;

  // Saturate a 66-bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/kaf_if.sv
// ----------------------------------------------------------------------------
// Channel interfaces for the Kalman angle filter
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface kaf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [kaf_pkg::DataW-1:0]   measured_angle;
  logic signed [kaf_pkg::DataW-1:0]   measured_rate;
  logic [kaf_pkg::TimeW-1:0]          step_time;
  modport source (output valid, measured_angle, measured_rate, step_time, input ready);
  modport sink (input valid, measured_angle, measured_rate, step_time, output ready);
endinterface

interface kaf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [kaf_pkg::DataW-1:0]   estimated_angle;
  modport source (output valid, estimated_angle, input ready);
  modport sink (input valid, estimated_angle, output ready);
endinterface

interface kaf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kaf_pkg::CfgIdxW-1:0]   index;
  logic [kaf_pkg::DataW-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/kaf_div.sv
// ----------------------------------------------------------------------------
// kaf_div: signed restoring divider
// Computes sat32((num << 24) / den) truncated toward zero, one bit a cycle.
// ----------------------------------------------------------------------------
module kaf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kaf_pkg::div_req_t   req_i,
  output kaf_pkg::div_rsp_t   rsp_o
);

  logic [55:0] rem_q, rem_d;
  logic [55:0] quo_q, quo_d;
  logic [32:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [56:0] trial;
  logic [56:0] qs;
  logic signed [65:0] qv;

  // Shift-subtract step on magnitudes
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[55]} - {24'd0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = {(req_i.num[31] ? 32'(-req_i.num) : 32'(req_i.num)), 24'd0};
      den_d  = req_i.den[32] ? 33'(-req_i.den) : 33'(req_i.den);
      neg_d  = req_i.num[31] ^ req_i.den[32];
      cnt_d  = 6'd56;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[56]) begin
        rem_d = trial[55:0];
        quo_d = {quo_q[54:0], 1'b1};
      end else begin
        rem_d = {rem_q[54:0], quo_q[55]};
        quo_d = {quo_q[54:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // Apply sign and saturate
  assign qs = {1'b0, quo_q};
  assign qv = neg_q ? -$signed({9'd0, qs}) : $signed({9'd0, qs});
  assign rsp_o.done = done_q;
  assign rsp_o.quot = kaf_pkg::sat32(qv);

endmodule

FILE: rtl/kalman_angle_filter.sv
// ----------------------------------------------------------------------------
// kalman_angle_filter: two-state angle/bias Kalman filter, fixed point
// ----------------------------------------------------------------------------
// Channels: in_if takes measured_angle, measured_rate (Q16.16) and step_time
// (Q0.24); out_if returns estimated_angle (Q16.16, saturated). cfg_if writes
// the three unsigned Q7.24 noise registers by index; writes to other indexes are
// dropped. Configure only while the filter is idle.
// Each item runs through a sequencer around one shared 33x33 multiplier with
// rounding and saturation, plus a shared one-bit-a-cycle divider for the two
// gains. From accept to result an item passes twelve multiply slots (ten
// carry a product), two divisions and four single steps. A zero innovation
// variance skips both divisions.
// in_if.ready is high only in the idle state, so one item is in work at a
// time and the next item waits until this one is done. The result sits
// in an output register until taken; meanwhile the next item is computed and
// then held until the register frees, so a stalled receiver stalls the input.
// Reset clears state and covariance to zero and loads the default noise.
// ----------------------------------------------------------------------------
module kalman_angle_filter (
  input logic        clk_i,
  input logic        rst_ni,
  kaf_in_if.sink     in_if,
  kaf_out_if.source  out_if,
  kaf_cfg_if.sink    cfg_if
);

  localparam logic [4:0] SIdle = 5'd0, SRate = 5'd1, SAng = 5'd2, SBb = 5'd3,
    SInner = 5'd4, SAa = 5'd5, SAb = 5'd6, SBbn = 5'd7, SS = 5'd8, SDiv0 = 5'd9,
    SDiv1 = 5'd10, SY = 5'd11, SK0y = 5'd12, SK1y = 5'd13, SK0a = 5'd14,
    SK0b = 5'd15, SK1a = 5'd16, SK1b = 5'd17, SOut = 5'd18;

  logic [4:0]  st_q, st_d;
  logic        ph_q;
  logic [30:0] qa_q, qb_q, r_q;
  logic signed [31:0] ang_q, bias_q, aa_q, ab_q, ba_q, bb_q;
  logic signed [31:0] meas_q, rate_q, k0_q, k1_q, y_q, p00_q, p01_q, t_q;
  logic [23:0] dt_q;
  logic signed [32:0] s_q;
  logic signed [31:0] res_q;
  logic        ovld_q;
  logic        out_load;

  // Shared multiplier operands and registered product
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_q;
  logic signed [65:0] rnd;
  logic signed [31:0] m;
  kaf_pkg::div_req_t dreq;
  kaf_pkg::div_rsp_t drsp;

  kaf_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_q)
      SAng:   begin ma = {9'd0, dt_q}; mb = {rate_q[31], rate_q}; end
      SBb:    begin ma = {9'd0, dt_q}; mb = {bb_q[31], bb_q}; end
      SInner: begin ma = {9'd0, dt_q}; mb = {t_q[31], t_q}; end
      SBbn:   begin ma = {2'd0, qb_q}; mb = {9'd0, dt_q}; end
      SK0y:   begin ma = {k0_q[31], k0_q}; mb = {y_q[31], y_q}; end
      SK1y:   begin ma = {k1_q[31], k1_q}; mb = {y_q[31], y_q}; end
      SK0a:   begin ma = {k0_q[31], k0_q}; mb = {p00_q[31], p00_q}; end
      SK0b:   begin ma = {k0_q[31], k0_q}; mb = {p01_q[31], p01_q}; end
      SK1a:   begin ma = {k1_q[31], k1_q}; mb = {p00_q[31], p00_q}; end
      SK1b:   begin ma = {k1_q[31], k1_q}; mb = {p01_q[31], p01_q}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Round to nearest (ties up) and saturate the registered product
  assign rnd = (prod_q + 66'sd8388608) >>> 24;
  assign m   = kaf_pkg::sat32(rnd);

  assign dreq.start = (st_q == SDiv0 || st_q == SDiv1) && !ph_q && s_q != '0;
  assign dreq.num   = (st_q == SDiv0) ? aa_q : ba_q;
  assign dreq.den   = s_q;

  // Result enters the output register once it is free or being taken
  assign out_load = (st_q == SOut) && (!ovld_q || out_if.ready);

  assign in_if.ready          = (st_q == SIdle);
  assign cfg_if.ready         = 1'b1;
  assign out_if.valid         = ovld_q;
  assign out_if.estimated_angle = res_q;

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      SIdle:  if (in_if.valid) st_d = SRate;
      SRate:  st_d = SAng;
      SS:     st_d = SDiv0;
      SDiv0, SDiv1: if (s_q == '0 || (ph_q && drsp.done)) st_d = st_q + 5'd1;
      SY:     st_d = SK0y;
      SOut:   if (out_load) st_d = SIdle;
      default: if (ph_q) st_d = st_q + 5'd1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SIdle;
      ph_q   <= 1'b0;
      qa_q   <= kaf_pkg::AngleNoiseRst;
      qb_q   <= kaf_pkg::BiasNoiseRst;
      r_q    <= kaf_pkg::MeasNoiseRst;
      ang_q  <= '0;
      bias_q <= '0;
      aa_q   <= '0;
      ab_q   <= '0;
      ba_q   <= '0;
      bb_q   <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      // divider states hold the phase high while waiting for the quotient
      ph_q <= (st_q == SDiv0 || st_q == SDiv1) ? (st_d == st_q) :
              ((st_d == st_q) ? ~ph_q : 1'b0);
      // register writes
      if (cfg_if.valid) begin
        case (cfg_if.index)
          kaf_pkg::RegAngleNoise: qa_q <= cfg_if.data[30:0];
          kaf_pkg::RegBiasNoise:  qb_q <= cfg_if.data[30:0];
          kaf_pkg::RegMeasNoise:  r_q  <= cfg_if.data[30:0];
          default: ;
        endcase
      end
      // output register
      if (out_load) begin
        res_q  <= ang_q;
        ovld_q <= 1'b1;
      end else if (out_if.ready && ovld_q) begin
        ovld_q <= 1'b0;
      end
      case (st_q)
        SIdle: if (in_if.valid) begin
          meas_q <= in_if.measured_angle;
          dt_q   <= in_if.step_time;
          rate_q <= in_if.measured_rate;
        end
        SRate: rate_q <= kaf_pkg::sat32(66'(rate_q) - 66'(bias_q));
        SAng: if (ph_q) ang_q <= kaf_pkg::sat32(66'(ang_q) + 66'(m));
        SBb: if (ph_q) t_q <= kaf_pkg::sat32(66'(m) - 66'(ab_q) - 66'(ba_q)
                                             + 66'(qa_q));
        SInner: if (ph_q) aa_q <= kaf_pkg::sat32(66'(aa_q) + 66'(m));
        SAa: if (ph_q) begin
          // no update here; ab and ba already took the bb*dt product in SBb
        end
        SBbn: if (ph_q) bb_q <= kaf_pkg::sat32(66'(bb_q) + 66'(m));
        SS: s_q <= 33'(aa_q) + 33'($signed({1'b0, r_q}));
        SDiv0: begin
          if (s_q == '0) k0_q <= '0;
          else if (ph_q && drsp.done) k0_q <= drsp.quot;
        end
        SDiv1: begin
          if (s_q == '0) k1_q <= '0;
          else if (ph_q && drsp.done) k1_q <= drsp.quot;
          y_q <= kaf_pkg::sat32(66'(meas_q) - 66'(ang_q));
        end
        SY: begin
          p00_q <= aa_q;
          p01_q <= ab_q;
        end
        SK0y: if (ph_q) ang_q  <= kaf_pkg::sat32(66'(ang_q) + 66'(m));
        SK1y: if (ph_q) bias_q <= kaf_pkg::sat32(66'(bias_q) + 66'(m));
        SK0a: if (ph_q) aa_q   <= kaf_pkg::sat32(66'(aa_q) - 66'(m));
        SK0b: if (ph_q) ab_q   <= kaf_pkg::sat32(66'(ab_q) - 66'(m));
        SK1a: if (ph_q) ba_q   <= kaf_pkg::sat32(66'(ba_q) - 66'(m));
        SK1b: if (ph_q) bb_q   <= kaf_pkg::sat32(66'(bb_q) - 66'(m));
        default: ;
      endcase
      // dt*bb product from SBb also updates ab and ba (old bb still held)
      if (st_q == SBb && ph_q) begin
        ab_q <= kaf_pkg::sat32(66'(ab_q) - 66'(m));
        ba_q <= kaf_pkg::sat32(66'(ba_q) - 66'(m));
      end
    end
  end

endmodule

FILE: tb/sv/tb_kalman_angle_filter.sv
// ----------------------------------------------------------------------------
// tb_kalman_angle_filter: self-checking bench for the Kalman angle filter
// Drives measurement items through a queue-fed driver, predicts each angle
// estimate with a local fixed-point filter model and compares it with every
// result the filter returns. Noise registers are rewritten between phases.
// ----------------------------------------------------------------------------
module tb_kalman_angle_filter;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainWait  = 400;
  localparam int unsigned HoldCycles = 600;
  localparam logic [kaf_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic signed [31:0] meas_angle;
    logic signed [31:0] meas_rate;
    logic [23:0]        dt;
  } sample_t;

  logic clk_i;
  logic rst_ni;

  kaf_in_if  in_if ();
  kaf_out_if out_if ();
  kaf_cfg_if cfg_if ();

  kalman_angle_filter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // Predictor state and noise settings
  logic [kaf_pkg::RegW-1:0] q_angle, q_bias, r_meas;
  logic signed [31:0] est_angle = '0, est_bias = '0;
  logic signed [31:0] p_aa = '0, p_ab = '0, p_ba = '0, p_bb = '0;

  sample_t            pending_samples[$];
  logic signed [31:0] expected_angles[$];
  int unsigned        n_errors = 0;
  int unsigned        cycle_count = 0;
  bit                 out_hold;
  bit                 hold_go = 1'b0;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Product shifted right by 24, round half up, saturated
  function automatic logic signed [31:0] qmul(input logic signed [127:0] a,
                                              input logic signed [127:0] b);
    logic signed [127:0] p;
    p = a * b + (128'sd1 <<< 23);
    return clip32(p >>> 24);
  endfunction

  // Gain in Q8.24, quotient truncated toward zero
  function automatic logic signed [31:0] kgain(input logic signed [31:0] num,
                                               input logic signed [127:0] s);
    logic signed [127:0] n;
    if (s == 0) return 32'sd0;
    n = 128'(num) <<< 24;
    return clip32(n / s);
  endfunction

  // Advance the filter by one measurement, return the new angle
  function automatic logic signed [31:0] filter_step(input sample_t smp);
    logic signed [127:0] dt, s;
    logic signed [31:0]  rate, inner, k0, k1, innov, p00, p01;
    dt = 128'(smp.dt);
    rate = clip32(128'(smp.meas_rate) - 128'(est_bias));
    est_angle = clip32(128'(est_angle) + 128'(qmul(dt, 128'(rate))));
    inner = clip32(128'(qmul(dt, 128'(p_bb))) - 128'(p_ab) - 128'(p_ba)
                   + 128'(q_angle));
    p_aa = clip32(128'(p_aa) + 128'(qmul(dt, 128'(inner))));
    p_ab = clip32(128'(p_ab) - 128'(qmul(dt, 128'(p_bb))));
    p_ba = clip32(128'(p_ba) - 128'(qmul(dt, 128'(p_bb))));
    p_bb = clip32(128'(p_bb) + 128'(qmul(128'(q_bias), dt)));
    s = 128'(p_aa) + 128'(r_meas);
    k0 = kgain(p_aa, s);
    k1 = kgain(p_ba, s);
    innov = clip32(128'(smp.meas_angle) - 128'(est_angle));
    est_angle = clip32(128'(est_angle) + 128'(qmul(128'(k0), 128'(innov))));
    est_bias = clip32(128'(est_bias) + 128'(qmul(128'(k1), 128'(innov))));
    p00 = p_aa;
    p01 = p_ab;
    p_aa = clip32(128'(p_aa) - 128'(qmul(128'(k0), 128'(p00))));
    p_ab = clip32(128'(p_ab) - 128'(qmul(128'(k0), 128'(p01))));
    p_ba = clip32(128'(p_ba) - 128'(qmul(128'(k1), 128'(p00))));
    p_bb = clip32(128'(p_bb) - 128'(qmul(128'(k1), 128'(p01))));
    return est_angle;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Long receiver stall, counted here once requested
  initial begin
    out_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    out_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    out_hold <= 1'b0;
  end

  // Input driver: pops queued samples, random gap before each
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.measured_angle <= '0;
      in_if.measured_rate <= '0;
      in_if.step_time <= '0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_angles.push_back(filter_step({in_if.measured_angle,
                                  in_if.measured_rate, in_if.step_time}));
        in_gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) in_gap = 0;
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_t smp;
          smp = pending_samples.pop_front();
          in_if.valid <= 1'b1;
          in_if.measured_angle <= smp.meas_angle;
          in_if.measured_rate <= smp.meas_rate;
          in_if.step_time <= smp.dt;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random receiver stalls
  int unsigned out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected angle result %0d", $time, out_if.estimated_angle);
          n_errors++;
        end else begin
          logic signed [31:0] exp_angle;
          exp_angle = expected_angles.pop_front();
          if (exp_angle !== out_if.estimated_angle) begin
            $display("%0t: estimated_angle expected %0d actual %0d",
                     $time, exp_angle, out_if.estimated_angle);
            n_errors++;
          end
        end
        out_gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) out_gap = 0;
      end
      if (out_hold) begin
        out_if.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Register write, done from the stimulus process at the clock edge
  task automatic write_reg(input logic [kaf_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      kaf_pkg::RegAngleNoise: q_angle = val[kaf_pkg::RegW-1:0];
      kaf_pkg::RegBiasNoise:  q_bias = val[kaf_pkg::RegW-1:0];
      kaf_pkg::RegMeasNoise:  r_meas = val[kaf_pkg::RegW-1:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until the filter has returned every result
  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_if.valid || expected_angles.size() > 0)
      @(negedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 32'($urandom());
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'(int'($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  function automatic logic [23:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return 24'($urandom());
      1: return $urandom_range(0, 1) ? 24'hffffff : 24'h0;
      default: return 24'($urandom_range(1000, 40000));
    endcase
  endfunction

  task automatic push_random(input int unsigned count);
    repeat (count) begin
      sample_t smp;
      smp.meas_angle = rand_angle();
      smp.meas_rate = rand_angle();
      smp.dt = rand_dt();
      pending_samples.push_back(smp);
    end
  endtask

  // Stimulus
  initial begin
    sample_t smp;
    q_angle = kaf_pkg::AngleNoiseRst;
    q_bias = kaf_pkg::BiasNoiseRst;
    r_meas = kaf_pkg::MeasNoiseRst;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, zero step, large innovation
    smp = '{32'sh0, 32'sh0, 24'h0};                 pending_samples.push_back(smp);
    smp = '{32'sh7fffffff, 32'sh7fffffff, 24'hffffff}; pending_samples.push_back(smp);
    smp = '{32'sh80000000, 32'sh80000000, 24'hffffff}; pending_samples.push_back(smp);
    smp = '{32'sh7fffffff, 32'sh80000000, 24'h000001}; pending_samples.push_back(smp);
    smp = '{32'sh80000000, 32'sh7fffffff, 24'h800000}; pending_samples.push_back(smp);
    smp = '{32'sh00010000, 32'shffff0000, 24'h004189}; pending_samples.push_back(smp);
    push_random(8);
    wait_idle();

    // Zero innovation variance: zero noise, zero covariance after a fresh start
    // is not reachable again, so drive measurement noise to the minimum
    write_reg(kaf_pkg::RegAngleNoise, 32'h0);
    write_reg(kaf_pkg::RegBiasNoise, 32'h0);
    write_reg(kaf_pkg::RegMeasNoise, 32'h1);
    write_reg(RegUnused, 32'hffffffff);
    smp = '{32'sh00050000, 32'sh0, 24'h0}; pending_samples.push_back(smp);
    push_random(6);
    wait_idle();

    // Largest noise values: negative innovation variance through saturation
    write_reg(kaf_pkg::RegAngleNoise, 32'hffffffff);
    write_reg(kaf_pkg::RegBiasNoise, 32'h7fffffff);
    write_reg(kaf_pkg::RegMeasNoise, 32'h7fffffff);
    push_random(40);
    wait_idle();

    // Long receiver stall while the sender keeps offering
    hold_go = 1'b1;
    push_random(20);
    wait_idle();

    // Random phases with varied noise settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(kaf_pkg::RegAngleNoise, $urandom());
      write_reg(kaf_pkg::RegBiasNoise, $urandom_range(0, 1 << 20));
      write_reg(kaf_pkg::RegMeasNoise, $urandom_range(1, 1 << 24));
      push_random(100);
      wait_idle();
    end
    write_reg(kaf_pkg::RegAngleNoise, 32'(kaf_pkg::AngleNoiseRst));
    write_reg(kaf_pkg::RegBiasNoise, 32'(kaf_pkg::BiasNoiseRst));
    write_reg(kaf_pkg::RegMeasNoise, 32'(kaf_pkg::MeasNoiseRst));
    push_random(80);
    wait_idle();

    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
